### sv/mps_pkg.sv
// mps_pkg: shared types, codes and constants of the moisture pump scheduler
// used by mps_ctrl, mps_dp and the top level moisture_pump_scheduler
`timescale 1ns / 1ps
`default_nettype none

package mps_pkg;

    localparam int NUM_PUMPS_DEF      = 4;
    localparam int SENSOR_ID_BITS_DEF = 8;

    localparam logic [6:0]  THR_RESET      = 7'd30;
    localparam logic [31:0] COOLDOWN_RESET = 32'd3600000;
    localparam logic [25:0] MS_PER_S       = 26'd1000;

    // request codes
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // result kinds
    localparam logic KIND_EVAL = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // configuration register indexes
    localparam logic CFG_DEFAULT_THRESHOLD = 1'b0;
    localparam logic CFG_COOLDOWN          = 1'b1;

    typedef enum logic [1:0] {
        WS_IDLE     = 2'd0,
        WS_ACTIVE   = 2'd1,
        WS_COOLDOWN = 2'd2,
        WS_WAIT     = 2'd3
    } t_water;

    typedef enum logic [1:0] {
        HS_UNKNOWN = 2'd0,
        HS_DRY     = 2'd1,
        HS_THIRSTY = 2'd2,
        HS_HEALTHY = 2'd3
    } t_humid;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_EMIT = 5'b00100,
        S_EV1  = 5'b01000,
        S_EV2  = 5'b10000
    } t_state;

    typedef struct packed {
        logic load_in;
        logic scan;
        logic emit;
        logic ev1;
        logic ev2;
    } t_dp_cmd;

    typedef struct packed {
        logic mask_empty;
        logic mask_last;
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic        kind;
        logic [1:0]  pump_number;
        logic [7:0]  owner;
        t_water      ws;
        t_humid      hs;
        logic [31:0] nlw;
        logic [31:0] nls;
        logic        changed;
        logic        pump_on;
        logic [25:0] dur;
        logic        cool;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

### sv/moisture_pump_scheduler.sv
// Moisture pump scheduler with NUM_PUMPS pump timers. One item is taken at a time. An evaluate
// item passes through the input registers, the first evaluation step (S_EV1) and the output
// register (S_EV2), and the next item is taken once its result is loaded. A tick scans the
// timers (S_SCAN) and then loads one completion beat per expired pump (S_EMIT); the next item
// is taken once the final beat is loaded. Each expired pump gives one completion beat in pump
// order, the final one flagged by last_of_run; a tick with no expired pump gives no beat.
// The controller walks one item through the datapath and the single output register, and a
// stall on the output side holds it before each result is loaded. Configuration writes are
// taken at any time, ready is always high, and must only be issued while idle.
// Depends on mps_pkg, mps_ctrl and mps_dp.
`timescale 1ns / 1ps
`default_nettype none

module moisture_pump_scheduler
    import mps_pkg::*;
#(
    parameter int NUM_PUMPS      = NUM_PUMPS_DEF,
    parameter int SENSOR_ID_BITS = SENSOR_ID_BITS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire               i_cfg_index,
    input  wire  [31:0]       i_cfg_data,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire               i_req_type,
    input  wire  [31:0]       i_now_ms,
    input  wire  [7:0]        i_sensor_id,
    input  wire signed [7:0]  i_moisture,
    input  wire  [6:0]        i_sensor_threshold,
    input  wire signed [3:0]  i_pump_index,
    input  wire  [15:0]       i_duration_s,
    input  wire  [31:0]       i_last_watered_ms,
    input  wire  [31:0]       i_last_seen_ms,
    input  wire  [1:0]        i_old_watering_state,
    input  wire  [1:0]        i_old_humidity_state,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic              o_result_kind,
    output logic [1:0]        o_pump_number,
    output logic [7:0]        o_owner_sensor,
    output logic [1:0]        o_watering_state,
    output logic [1:0]        o_humidity_state,
    output logic [31:0]       o_new_last_watered_ms,
    output logic [31:0]       o_new_last_seen_ms,
    output logic              o_record_changed,
    output logic              o_pump_on,
    output logic [25:0]       o_pump_duration_ms,
    output logic              o_cooldown_active,
    output logic              o_last_of_run
);

    t_dp_cmd    cmd;
    t_dp_status sts;
    t_result    res;

    assign o_cfg_ready = 1'b1;

    mps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    mps_dp #(
        .NUM_PUMPS      (NUM_PUMPS),
        .SENSOR_ID_BITS (SENSOR_ID_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_cfg_we             (i_cfg_valid && o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_now_ms             (i_now_ms),
        .i_sensor_id          (i_sensor_id),
        .i_moisture           (i_moisture),
        .i_sensor_threshold   (i_sensor_threshold),
        .i_pump_index         (i_pump_index),
        .i_duration_s         (i_duration_s),
        .i_last_watered_ms    (i_last_watered_ms),
        .i_last_seen_ms       (i_last_seen_ms),
        .i_old_watering_state (i_old_watering_state),
        .i_old_humidity_state (i_old_humidity_state),
        .i_out_stall          (i_out_stall),
        .o_out_valid          (o_out_valid),
        .o_out                (res)
    );

    assign o_result_kind         = res.kind;
    assign o_pump_number         = res.pump_number;
    assign o_owner_sensor        = res.owner;
    assign o_watering_state      = res.ws;
    assign o_humidity_state      = res.hs;
    assign o_new_last_watered_ms = res.nlw;
    assign o_new_last_seen_ms    = res.nls;
    assign o_record_changed      = res.changed;
    assign o_pump_on             = res.pump_on;
    assign o_pump_duration_ms    = res.dur;
    assign o_cooldown_active     = res.cool;
    assign o_last_of_run         = res.last;

endmodule

`default_nettype wire

### sv/mps_ctrl.sv
// mps_ctrl: sequencing state machine of the moisture pump scheduler
// depends on mps_pkg; drives mps_dp through t_dp_cmd and reads t_dp_status
`timescale 1ns / 1ps
`default_nettype none

module mps_ctrl
    import mps_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_req_type,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_sts
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = (i_req_type == REQ_TICK) ? S_SCAN : S_EV1;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.mask_empty) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.mask_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EV1: begin
                o_cmd.ev1 = 1'b1;
                n_state   = S_EV2;
            end
            S_EV2: begin
                if (i_sts.out_free) begin
                    o_cmd.ev2 = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_in |=> (r_state == S_SCAN || r_state == S_EV1))
        else $error("item taken outside idle");

    a_result_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit || o_cmd.ev2) |-> i_sts.out_free)
        else $error("result loaded while output register occupied");

    a_stall_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input open while an item is in flight");

endmodule

`default_nettype wire

### sv/mps_dp.sv
// mps_dp: datapath of the moisture pump scheduler: input and config registers,
// pump timers, two-step evaluation, expiry mask and the output register; uses mps_pkg
`timescale 1ns / 1ps
`default_nettype none

module mps_dp
    import mps_pkg::*;
#(
    parameter int NUM_PUMPS      = NUM_PUMPS_DEF,
    parameter int SENSOR_ID_BITS = SENSOR_ID_BITS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_sts,
    input  wire               i_cfg_we,
    input  wire               i_cfg_index,
    input  wire  [31:0]       i_cfg_data,
    input  wire  [31:0]       i_now_ms,
    input  wire  [7:0]        i_sensor_id,
    input  wire signed [7:0]  i_moisture,
    input  wire  [6:0]        i_sensor_threshold,
    input  wire signed [3:0]  i_pump_index,
    input  wire  [15:0]       i_duration_s,
    input  wire  [31:0]       i_last_watered_ms,
    input  wire  [31:0]       i_last_seen_ms,
    input  wire  [1:0]        i_old_watering_state,
    input  wire  [1:0]        i_old_humidity_state,
    input  wire               i_out_stall,
    output logic              o_out_valid,
    output t_result           o_out
);

    localparam int PW = (NUM_PUMPS > 1) ? $clog2(NUM_PUMPS) : 1;

    // configuration
    logic [6:0]  r_def_thr;
    logic [31:0] r_cooldown;

    // captured item
    logic [31:0]               r_now;
    logic [SENSOR_ID_BITS-1:0] r_sid;
    logic signed [7:0]         r_moist;
    logic [6:0]                r_sthr;
    logic signed [3:0]         r_pidx;
    logic [15:0]               r_dur;
    logic [31:0]               r_lw;
    logic [31:0]               r_ls;
    logic [1:0]                r_old_ws;
    logic [1:0]                r_old_hs;

    // first evaluation step
    logic [31:0]   r_lw_fix;
    logic [31:0]   r_ls_fix;
    logic          r_roll;
    logic [6:0]    r_thr;
    logic [25:0]   r_run;
    logic [31:0]   r_diff;
    logic          r_pvalid;
    logic [PW-1:0] r_p;

    // pump timers
    logic [NUM_PUMPS-1:0]      r_running;
    logic [NUM_PUMPS-1:0]      n_running;
    logic [31:0]               r_start [NUM_PUMPS];
    logic [25:0]               r_len   [NUM_PUMPS];
    logic [SENSOR_ID_BITS-1:0] r_owner [NUM_PUMPS];
    logic [NUM_PUMPS-1:0]      r_mask;
    logic [NUM_PUMPS-1:0]      n_mask;

    t_result r_out;
    logic    r_out_valid;
    logic    n_out_valid;

    logic                 roll;
    logic                 pidx_ok;
    logic [NUM_PUMPS-1:0] expired;
    logic [NUM_PUMPS-1:0] first_bit;
    logic [PW-1:0]        first_idx;
    logic                 cool;
    logic                 ls_before_lw;
    logic signed [9:0]    m10;
    logic signed [9:0]    t10;
    logic signed [9:0]    t2x;
    t_water               ev_ws;
    t_humid               ev_hs;
    logic                 start;
    logic                 changed;
    t_result              done_res;
    t_result              eval_res;

    assign o_out_valid    = r_out_valid;
    assign o_out          = r_out;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_sts.mask_empty = (r_mask == '0);
    assign o_sts.mask_last  = ((r_mask & (r_mask - 1'b1)) == '0);

    assign roll = (r_lw > r_now);

    // a pump index outside the timers falls back to pump 0
    assign pidx_ok = !r_pidx[3] && (int'(r_pidx[2:0]) < NUM_PUMPS);

    always_comb begin
        for (int i = 0; i < NUM_PUMPS; i++) begin
            expired[i] = r_running[i] && ((r_now - r_start[i]) >= {6'b0, r_len[i]});
        end
    end

    // lowest pending pump goes out first
    assign first_bit = r_mask & (~r_mask + 1'b1);
    always_comb begin
        first_idx = '0;
        for (int i = NUM_PUMPS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                first_idx = PW'(i);
            end
        end
    end

    // second evaluation step
    always_comb begin
        cool         = r_pvalid && (r_lw_fix != '0) && (r_diff < r_cooldown);
        ls_before_lw = (r_ls_fix < r_lw_fix);
        m10 = {{2{r_moist[7]}}, r_moist};
        t10 = $signed({3'b000, r_thr});
        t2x = $signed({2'b00, r_thr, 1'b0});
        ev_ws = WS_IDLE;
        if (r_pvalid) begin
            if (r_running[r_p]) begin
                ev_ws = WS_ACTIVE;
            end else if (cool) begin
                ev_ws = WS_COOLDOWN;
            end else if (ls_before_lw) begin
                ev_ws = WS_WAIT;
            end
        end
        if (r_moist == -8'sd1) begin
            ev_hs = HS_UNKNOWN;
        end else if ((r_lw_fix != '0) && ls_before_lw) begin
            ev_hs = HS_UNKNOWN;
        end else if (m10 <= t10) begin
            ev_hs = HS_DRY;
        end else if (m10 <= t2x) begin
            ev_hs = HS_THIRSTY;
        end else begin
            ev_hs = HS_HEALTHY;
        end
        start = r_pvalid && (ev_ws == WS_IDLE) && (ev_hs == HS_DRY);
        if (start) begin
            ev_ws = WS_ACTIVE;
            ev_hs = HS_UNKNOWN;
        end
        changed = r_roll || (r_old_ws != ev_ws) || (r_old_hs != ev_hs);
    end

    always_comb begin
        eval_res.kind        = KIND_EVAL;
        eval_res.pump_number = 2'(r_p);
        eval_res.owner       = 8'(r_sid);
        eval_res.ws          = ev_ws;
        eval_res.hs          = ev_hs;
        eval_res.nlw         = r_lw_fix;
        eval_res.nls         = r_ls_fix;
        eval_res.changed     = changed;
        eval_res.pump_on     = start;
        eval_res.dur         = start ? r_run : '0;
        eval_res.cool        = cool;
        eval_res.last        = 1'b1;

        done_res.kind        = KIND_DONE;
        done_res.pump_number = 2'(first_idx);
        done_res.owner       = 8'(r_owner[first_idx]);
        done_res.ws          = WS_IDLE;
        done_res.hs          = HS_UNKNOWN;
        done_res.nlw         = r_now;
        done_res.nls         = '0;
        done_res.changed     = 1'b1;
        done_res.pump_on     = 1'b0;
        done_res.dur         = '0;
        done_res.cool        = 1'b1;
        done_res.last        = o_sts.mask_last;
    end

    always_comb begin
        n_running   = r_running;
        n_mask      = r_mask;
        n_out_valid = r_out_valid && i_out_stall;
        if (i_cmd.scan) begin
            n_mask    = expired;
            n_running = r_running & ~expired;
        end
        if (i_cmd.emit) begin
            n_mask      = r_mask & ~first_bit;
            n_out_valid = 1'b1;
        end
        if (i_cmd.ev2) begin
            n_out_valid = 1'b1;
            if (start) begin
                n_running[r_p] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
            r_def_thr   <= THR_RESET;
            r_cooldown  <= COOLDOWN_RESET;
        end else begin
            r_running   <= n_running;
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DEFAULT_THRESHOLD: r_def_thr  <= i_cfg_data[6:0];
                    CFG_COOLDOWN:          r_cooldown <= i_cfg_data;
                    default:               r_cooldown <= r_cooldown;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_now    <= i_now_ms;
            r_sid    <= SENSOR_ID_BITS'(i_sensor_id);
            r_moist  <= i_moisture;
            r_sthr   <= i_sensor_threshold;
            r_pidx   <= i_pump_index;
            r_dur    <= i_duration_s;
            r_lw     <= i_last_watered_ms;
            r_ls     <= i_last_seen_ms;
            r_old_ws <= i_old_watering_state;
            r_old_hs <= i_old_humidity_state;
        end
        if (i_cmd.ev1) begin
            r_roll   <= roll;
            r_lw_fix <= roll ? '0 : r_lw;
            r_ls_fix <= roll ? r_now : r_ls;
            r_diff   <= r_now - (roll ? 32'd0 : r_lw);
            r_thr    <= (r_sthr != '0) ? r_sthr : r_def_thr;
            r_run    <= 26'(r_dur) * MS_PER_S;
            r_pvalid <= pidx_ok;
            r_p      <= pidx_ok ? PW'(r_pidx[2:0]) : '0;
        end
        if (i_cmd.ev2 && start) begin
            r_start[r_p] <= r_now;
            r_len[r_p]   <= r_run;
            r_owner[r_p] <= r_sid;
        end
        if (i_cmd.emit) begin
            r_out <= done_res;
        end else if (i_cmd.ev2) begin
            r_out <= eval_res;
        end
    end

    a_emit_has_pump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_mask != '0))
        else $error("completion with no pending pump");

    a_scan_stops_pumps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |=> ((r_mask & r_running) == '0))
        else $error("expired pump still marked running");

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ev2 && start) |=> r_running[r_p])
        else $error("started pump not running");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && o_sts.mask_last) |=> (r_mask == '0))
        else $error("pumps left after final completion");

endmodule

`default_nettype wire

### sim/tb_moisture_pump_scheduler.sv
// tb_moisture_pump_scheduler: self-checking bench for the moisture pump scheduler, with its own
// model of the pump timers, random idling on both channels and register changes between phases
// depends on mps_pkg and moisture_pump_scheduler
`timescale 1ns / 1ps

module tb_moisture_pump_scheduler;
    import mps_pkg::*;

    localparam int NUM_PUMPS = 4;

    typedef struct {
        logic        req_type;
        logic [31:0] now_ms;
        logic [7:0]  sensor_id;
        logic [7:0]  moisture;
        logic [6:0]  threshold;
        logic [3:0]  pump_index;
        logic [15:0] duration_s;
        logic [31:0] last_watered;
        logic [31:0] last_seen;
        logic [1:0]  old_ws;
        logic [1:0]  old_hs;
    } t_sensor_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_DEFAULT_THRESHOLD;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_req_type = REQ_TICK;
    logic [31:0] i_now_ms = '0;
    logic [7:0]  i_sensor_id = '0;
    logic [7:0]  i_moisture = '0;
    logic [6:0]  i_sensor_threshold = '0;
    logic [3:0]  i_pump_index = '0;
    logic [15:0] i_duration_s = '0;
    logic [31:0] i_last_watered_ms = '0;
    logic [31:0] i_last_seen_ms = '0;
    logic [1:0]  i_old_watering_state = '0;
    logic [1:0]  i_old_humidity_state = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_result_kind;
    logic [1:0]  o_pump_number;
    logic [7:0]  o_owner_sensor;
    logic [1:0]  o_watering_state;
    logic [1:0]  o_humidity_state;
    logic [31:0] o_new_last_watered_ms;
    logic [31:0] o_new_last_seen_ms;
    logic        o_record_changed;
    logic        o_pump_on;
    logic [25:0] o_pump_duration_ms;
    logic        o_cooldown_active;
    logic        o_last_of_run;

    // model state: registers and pump timers
    logic [6:0]  cfg_thr = THR_RESET;
    logic [31:0] cfg_cool = COOLDOWN_RESET;
    logic        pump_running[NUM_PUMPS];
    logic [31:0] pump_start[NUM_PUMPS];
    logic [25:0] pump_len[NUM_PUMPS];
    logic [7:0]  pump_owner[NUM_PUMPS];

    t_sensor_req req_q[$];
    t_result     outcome_q[$];
    t_sensor_req cur_req;
    int          err_count = 0;
    int          drv_gap = 0;
    int          drv_calm = 0;
    int          snk_gap = 0;
    int          snk_calm = 0;
    bit          quiet = 1'b0;
    logic [31:0] sim_now;

    moisture_pump_scheduler dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_req_type           (i_req_type),
        .i_now_ms             (i_now_ms),
        .i_sensor_id          (i_sensor_id),
        .i_moisture           (i_moisture),
        .i_sensor_threshold   (i_sensor_threshold),
        .i_pump_index         (i_pump_index),
        .i_duration_s         (i_duration_s),
        .i_last_watered_ms    (i_last_watered_ms),
        .i_last_seen_ms       (i_last_seen_ms),
        .i_old_watering_state (i_old_watering_state),
        .i_old_humidity_state (i_old_humidity_state),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_result_kind        (o_result_kind),
        .o_pump_number        (o_pump_number),
        .o_owner_sensor       (o_owner_sensor),
        .o_watering_state     (o_watering_state),
        .o_humidity_state     (o_humidity_state),
        .o_new_last_watered_ms(o_new_last_watered_ms),
        .o_new_last_seen_ms   (o_new_last_seen_ms),
        .o_record_changed     (o_record_changed),
        .o_pump_on            (o_pump_on),
        .o_pump_duration_ms   (o_pump_duration_ms),
        .o_cooldown_active    (o_cooldown_active),
        .o_last_of_run        (o_last_of_run)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < NUM_PUMPS; i++) begin
            pump_running[i] = 1'b0;
            pump_start[i]   = '0;
            pump_len[i]     = '0;
            pump_owner[i]   = '0;
        end
    end

    function automatic t_sensor_req make_req(logic kind, logic [31:0] now, logic [7:0] sid,
                                             logic [7:0] moist, logic [6:0] thr,
                                             logic [3:0] pidx, logic [15:0] dur,
                                             logic [31:0] lw, logic [31:0] ls,
                                             logic [1:0] ows, logic [1:0] ohs);
        t_sensor_req r;
        r.req_type     = kind;
        r.now_ms       = now;
        r.sensor_id    = sid;
        r.moisture     = moist;
        r.threshold    = thr;
        r.pump_index   = pidx;
        r.duration_s   = dur;
        r.last_watered = lw;
        r.last_seen    = ls;
        r.old_ws       = ows;
        r.old_hs       = ohs;
        return r;
    endfunction

    function automatic t_sensor_req tick_at(logic [31:0] now);
        return make_req(REQ_TICK, now, '0, '0, '0, '0, '0, '0, '0, '0, '0);
    endfunction

    function automatic t_sensor_req eval_req(logic [31:0] now, logic [7:0] sid,
                                             logic [7:0] moist, logic [6:0] thr,
                                             logic [3:0] pidx, logic [15:0] dur,
                                             logic [31:0] lw, logic [31:0] ls);
        return make_req(REQ_EVAL, now, sid, moist, thr, pidx, dur, lw, ls, WS_IDLE, HS_UNKNOWN);
    endfunction

    // works out the results one accepted beat causes and updates the pump timers
    task automatic schedule_outcome(input t_sensor_req r);
        t_result     res;
        t_result     done[NUM_PUMPS];
        int          n;
        int          i;
        int          m;
        int          thr;
        int          pidx;
        int          p;
        bit          has_pump;
        bit          cool;
        bit          start;
        bit          changed;
        t_water      ws;
        t_humid      hs;
        logic [31:0] lw;
        logic [31:0] ls;
        logic [31:0] elapsed;
        logic [25:0] run;

        if (r.req_type == REQ_TICK) begin
            n = 0;
            for (i = 0; i < NUM_PUMPS; i++) begin
                elapsed = r.now_ms - pump_start[i];
                if (pump_running[i] && elapsed >= {6'b0, pump_len[i]}) begin
                    pump_running[i]         = 1'b0;
                    done[n].kind            = KIND_DONE;
                    done[n].pump_number     = 2'(i);
                    done[n].owner           = pump_owner[i];
                    done[n].ws              = WS_IDLE;
                    done[n].hs              = HS_UNKNOWN;
                    done[n].nlw             = r.now_ms;
                    done[n].nls             = '0;
                    done[n].changed         = 1'b1;
                    done[n].pump_on         = 1'b0;
                    done[n].dur             = '0;
                    done[n].cool            = 1'b1;
                    done[n].last            = 1'b0;
                    n++;
                end
            end
            if (n > 0)
                done[n - 1].last = 1'b1;
            for (i = 0; i < n; i++)
                outcome_q.push_back(done[i]);
        end else begin
            m        = $signed(r.moisture);
            pidx     = $signed(r.pump_index);
            thr      = (r.threshold != 0) ? r.threshold : cfg_thr;
            has_pump = pidx >= 0 && pidx < NUM_PUMPS;
            p        = has_pump ? pidx : 0;
            lw       = r.last_watered;
            ls       = r.last_seen;
            changed  = 1'b0;
            cool     = 1'b0;
            start    = 1'b0;
            ws       = WS_IDLE;
            run      = '0;

            // clock went backwards: forget the watering time
            if (lw > r.now_ms) begin
                lw      = '0;
                ls      = r.now_ms;
                changed = 1'b1;
            end

            if (has_pump) begin
                cool = lw != 0 && (r.now_ms - lw) < cfg_cool;
                if (pump_running[p])
                    ws = WS_ACTIVE;
                else if (cool)
                    ws = WS_COOLDOWN;
                else if (ls < lw)
                    ws = WS_WAIT;
            end

            if (m == -1)
                hs = HS_UNKNOWN;
            else if (lw != 0 && ls < lw)
                hs = HS_UNKNOWN;
            else if (m <= thr)
                hs = HS_DRY;
            else if (m <= 2 * thr)
                hs = HS_THIRSTY;
            else
                hs = HS_HEALTHY;

            if (has_pump && ws == WS_IDLE && hs == HS_DRY) begin
                run             = r.duration_s * MS_PER_S;
                pump_running[p] = 1'b1;
                pump_start[p]   = r.now_ms;
                pump_len[p]     = run;
                pump_owner[p]   = r.sensor_id;
                start           = 1'b1;
                ws              = WS_ACTIVE;
                hs              = HS_UNKNOWN;
            end

            if (r.old_ws != ws || r.old_hs != hs)
                changed = 1'b1;

            res.kind        = KIND_EVAL;
            res.pump_number = 2'(p);
            res.owner       = r.sensor_id;
            res.ws          = ws;
            res.hs          = hs;
            res.nlw         = lw;
            res.nls         = ls;
            res.changed     = changed;
            res.pump_on     = start;
            res.dur         = run;
            res.cool        = cool;
            res.last        = 1'b1;
            outcome_q.push_back(res);
        end
    endtask

    // mostly plausible records around a running clock, with some raw noise
    function automatic t_sensor_req rand_req();
        t_sensor_req r;
        int          k;
        r = make_req(REQ_EVAL, '0, 8'($urandom_range(0, 255)), '0, '0, '0, '0, '0, '0,
                     2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
        if ($urandom_range(0, 99) < 30) begin
            r.req_type = REQ_TICK;
            sim_now    = sim_now + $urandom_range(0, 3000);
            r.now_ms   = ($urandom_range(0, 99) < 5) ? $urandom() : sim_now;
            r.moisture = 8'($urandom());
            return r;
        end
        sim_now  = sim_now + $urandom_range(0, 200);
        r.now_ms = sim_now;

        k = $urandom_range(0, 99);
        r.pump_index = (k < 75) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));

        k = $urandom_range(0, 99);
        if (k < 10)
            r.moisture = 8'hFF;
        else if (k < 20)
            r.moisture = 8'($urandom_range(0, 255));
        else
            r.moisture = 8'($urandom_range(0, (k < 60) ? 60 : 100));

        k = $urandom_range(0, 99);
        if (k < 25)
            r.threshold = '0;
        else if (k < 35)
            r.threshold = 7'($urandom_range(0, 127));
        else
            r.threshold = 7'($urandom_range(1, 100));

        k = $urandom_range(0, 99);
        if (k < 85)
            r.duration_s = 16'($urandom_range(0, 4));
        else if (k < 95)
            r.duration_s = 16'($urandom_range(0, 60));
        else
            r.duration_s = 16'($urandom());

        k = $urandom_range(0, 99);
        if (k < 40)
            r.last_watered = '0;
        else if (k < 60)
            r.last_watered = r.now_ms - $urandom_range(0, 20000);
        else if (k < 70)
            r.last_watered = r.now_ms + $urandom_range(1, 1000);
        else if (k < 80)
            r.last_watered = $urandom();
        else
            r.last_watered = r.now_ms - $urandom_range(0, 8000000);

        k = $urandom_range(0, 99);
        if (k < 60)
            r.last_seen = r.now_ms - $urandom_range(0, 500);
        else if (k < 80)
            r.last_seen = r.last_watered;
        else if (k < 90)
            r.last_seen = r.last_watered - 1;
        else
            r.last_seen = $urandom();
        return r;
    endfunction

    task automatic load_random(input int count);
        repeat (count) req_q.push_back(rand_req());
    endtask

    // waits until nothing is queued, in flight or owed, then lets a silent tick finish
    task automatic wait_drained();
        do @(posedge i_clk);
        while (req_q.size() != 0 || i_in_valid || outcome_q.size() != 0);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [6:0] thr, input logic [31:0] cool);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_DEFAULT_THRESHOLD;
        i_cfg_data  <= {25'b0, thr};
        do @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_thr     = thr;
        i_cfg_index <= CFG_COOLDOWN;
        i_cfg_data  <= cool;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_cool    = cool;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            err_count++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall)
            schedule_outcome(cur_req);
        if (!i_in_valid || !o_in_stall) begin
            if (drv_gap > 0) begin
                drv_gap--;
                i_in_valid <= 1'b0;
            end else if (req_q.size() != 0) begin
                if (drv_calm > 0)
                    drv_calm--;
                else if ($urandom_range(0, 49) == 0)
                    drv_calm = $urandom_range(10, 40);
                if (!quiet && drv_calm == 0 && $urandom_range(0, 3) == 0) begin
                    drv_gap    = $urandom_range(1, 5) - 1;
                    i_in_valid <= 1'b0;
                end else begin
                    cur_req = req_q.pop_front();
                    i_req_type           <= cur_req.req_type;
                    i_now_ms             <= cur_req.now_ms;
                    i_sensor_id          <= cur_req.sensor_id;
                    i_moisture           <= cur_req.moisture;
                    i_sensor_threshold   <= cur_req.threshold;
                    i_pump_index         <= cur_req.pump_index;
                    i_duration_s         <= cur_req.duration_s;
                    i_last_watered_ms    <= cur_req.last_watered;
                    i_last_seen_ms       <= cur_req.last_seen;
                    i_old_watering_state <= cur_req.old_ws;
                    i_old_humidity_state <= cur_req.old_hs;
                    i_in_valid           <= 1'b1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor and output back-pressure
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (outcome_q.size() == 0) begin
                $error("result beat with nothing expected: kind %0h pump %0h",
                       o_result_kind, o_pump_number);
                err_count++;
            end else begin
                e = outcome_q.pop_front();
                check_field("result_kind", e.kind, o_result_kind);
                check_field("pump_number", e.pump_number, o_pump_number);
                check_field("owner_sensor", e.owner, o_owner_sensor);
                check_field("watering_state", e.ws, o_watering_state);
                check_field("humidity_state", e.hs, o_humidity_state);
                check_field("new_last_watered_ms", e.nlw, o_new_last_watered_ms);
                check_field("new_last_seen_ms", e.nls, o_new_last_seen_ms);
                check_field("record_changed", e.changed, o_record_changed);
                check_field("pump_on", e.pump_on, o_pump_on);
                check_field("pump_duration_ms", e.dur, o_pump_duration_ms);
                check_field("cooldown_active", e.cool, o_cooldown_active);
                check_field("last_of_run", e.last, o_last_of_run);
            end
        end
        if (snk_calm > 0)
            snk_calm--;
        else if ($urandom_range(0, 99) == 0)
            snk_calm = $urandom_range(20, 80);
        if (snk_gap > 0) begin
            snk_gap--;
            i_out_stall <= 1'b1;
        end else if (!quiet && snk_calm == 0 && $urandom_range(0, 5) == 0) begin
            snk_gap     = $urandom_range(1, 5) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin
        logic [31:0] t0;
        logic [6:0]  thr_tab[4];
        logic [31:0] cool_tab[4];

        t0      = 32'h1000_0000;
        sim_now = $urandom();
        thr_tab  = '{7'd0, 7'd100, 7'($urandom_range(1, 100)), THR_RESET};
        cool_tab = '{32'd0, 32'hFFFF_FFFF, 32'($urandom_range(0, 20000)), COOLDOWN_RESET};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset register values
        req_q.push_back(tick_at(t0));
        req_q.push_back(eval_req(t0, 8'h00, 8'd10, 7'd0, 4'd0, 16'd0, 0, 0));
        req_q.push_back(eval_req(t0, 8'hFF, 8'd0, 7'd100, 4'd1, 16'hFFFF, 0, t0));
        req_q.push_back(eval_req(t0, 8'd2, 8'hFF, 7'd0, 4'd2, 16'd1, 0, t0));
        req_q.push_back(make_req(REQ_EVAL, t0, 8'd3, 8'd100, 7'd0, 4'd3, 16'd1, 0, t0,
                                 WS_IDLE, HS_HEALTHY));
        req_q.push_back(eval_req(t0, 8'd3, 8'd45, 7'd0, 4'd3, 16'd1, 0, t0));
        // negative reading that is not the missing marker counts as dry
        req_q.push_back(eval_req(t0, 8'd3, 8'h80, 7'd1, 4'd3, 16'd2, 0, t0));
        req_q.push_back(eval_req(t0, 8'd7, 8'd5, 7'd0, 4'd0, 16'd9, 0, t0));
        req_q.push_back(eval_req(t0, 8'd9, 8'd5, 7'd0, 4'hF, 16'd1, 0, t0));
        req_q.push_back(eval_req(t0, 8'd9, 8'd5, 7'd0, 4'd7, 16'd1, 0, t0));
        req_q.push_back(eval_req(t0, 8'd9, 8'd5, 7'd0, 4'h8, 16'd1, 0, t0));
        req_q.push_back(eval_req(t0, 8'd2, 8'd50, 7'd0, 4'd2, 16'd1, t0 + 5, t0));
        req_q.push_back(eval_req(t0, 8'd2, 8'd10, 7'd0, 4'd2, 16'd1, t0 - 1000, t0));
        req_q.push_back(eval_req(t0, 8'd2, 8'd10, 7'd0, 4'd2, 16'd1, t0 - 4000000,
                                 t0 - 5000000));
        // threshold above one hundred is taken as it stands
        req_q.push_back(eval_req(t0, 8'd2, 8'd100, 7'd127, 4'd2, 16'd1, 0, t0));
        req_q.push_back(tick_at(t0 + 1500));
        req_q.push_back(tick_at(t0 + 2000));
        req_q.push_back(tick_at(t0 + 65535000));
        req_q.push_back(eval_req(32'hFFFF_FFFF, 8'd4, 8'd10, 7'd0, 4'd0, 16'd1,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        req_q.push_back(eval_req(0, 8'd11, 8'd30, 7'd0, 4'd1, 16'd3, 0, 0));
        req_q.push_back(eval_req(0, 8'd10, 8'd0, 7'd0, 4'd0, 16'd1, 0, 0));
        req_q.push_back(eval_req(0, 8'd12, 8'd0, 7'd0, 4'd2, 16'd0, 0, 0));
        req_q.push_back(eval_req(0, 8'd13, 8'd0, 7'd0, 4'd3, 16'd2, 0, 0));
        req_q.push_back(tick_at(32'd5000));
        req_q.push_back(tick_at(32'd5000));
        load_random(60);

        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            program_regs(thr_tab[ph], cool_tab[ph]);
            if (ph == 3)
                quiet = 1'b1;
            load_random(64);
        end
        wait_drained();

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
